// File: hw/rtl/crc8rcp_pkg.sv
`timescale 1ns / 1ps
package crc8rcp_pkg;

  // Frame buffer geometry
  localparam int MaxFrame = 8;
  localparam int IdxW     = $clog2(MaxFrame);
  localparam int CntW     = $clog2(MaxFrame + 1);
  localparam int FrameLen = 6;

  // Frame markers and CRC polynomial
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] HdrCmd  = 8'hEE;
  localparam logic [7:0] HdrJoy  = 8'hCC;
  localparam logic [7:0] Mark02  = 8'h02;
  localparam logic [7:0] TailFf  = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CfgSpeed  = 2'd0;
  localparam logic [1:0] CfgSwitch = 2'd1;
  localparam logic [1:0] CfgHold   = 2'd2;

  // Bytes covered by the check, minus one
  localparam logic [2:0] CmdLastByte = 3'd3;
  localparam logic [2:0] JoyLastByte = 3'd4;

  typedef struct packed {
    logic       start;
    logic [2:0] last_idx;
  } crc_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [2:0] idx;
  } crc_rsp_t;

endpackage

// File: hw/rtl/crc8_remote_command_parser_unit.sv
// Result: a completed command or joystick frame shows its result once the CRC check over
//   its bytes finishes; other bytes give no result.
// Throughput: one byte per cycle while no check runs; the bit-serial CRC unit (one bit a
//   cycle over 4 or 5 bytes) holds input off from a frame's last byte until the check is done,
//   and a frame's sixth byte waits as long as the previous result has not been taken.
// Reset: asynchronous, active low; idle, no frame open, codes back to 7, 8 and 9.
`timescale 1ns / 1ps
module crc8_remote_command_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_kind_o,
  output logic       crc_ok_o,
  output logic       speed_valid_o,
  output logic [7:0] speed_value_o,
  output logic       switch_valid_o,
  output logic [7:0] switch_value_o,
  output logic       hold_start_o,
  output logic       steer_valid_o,
  output logic [7:0] steer_value_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CRC  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [7:0] speed_code_q, switch_code_q, hold_code_q;
  logic [7:0] fb_q [crc8rcp_pkg::MaxFrame];
  logic [crc8rcp_pkg::CntW-1:0] count_q, count_d, wr_idx, cnt_new;
  logic       in_frame_q, in_frame_d;
  logic       kind_q, kind_d;
  logic [7:0] chk_q, chk_d;
  logic       out_valid_q;

  logic in_acc, out_acc, hdr, active, at_last, cmd_match, joy_match, ok;

  crc8rcp_pkg::crc_req_t crc_req;
  crc8rcp_pkg::crc_rsp_t crc_rsp;
  logic [7:0] crc_val;
  logic [7:0] crc_data;

  assign crc_data = fb_q[crc8rcp_pkg::IdxW'(crc_rsp.idx)];

  crc8rcp_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .data_i (crc_data),
    .rsp_o  (crc_rsp),
    .crc_o  (crc_val)
  );

  // Hold input while checking, and before a sixth byte while a result still waits
  assign at_last    = in_frame_q &&
                      (count_q == crc8rcp_pkg::CntW'(crc8rcp_pkg::FrameLen - 1));
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && at_last);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign hdr       = (rx_byte_i == crc8rcp_pkg::HdrCmd) || (rx_byte_i == crc8rcp_pkg::HdrJoy);
  assign active    = in_frame_q || hdr;
  assign wr_idx    = in_frame_q ? count_q : '0;
  assign cnt_new   = wr_idx + crc8rcp_pkg::CntW'(1);
  assign cmd_match = at_last && (fb_q[0] == crc8rcp_pkg::HdrCmd) &&
                     (fb_q[1] == crc8rcp_pkg::Mark02) && (rx_byte_i == crc8rcp_pkg::TailFf);
  assign joy_match = at_last && (fb_q[0] == crc8rcp_pkg::HdrJoy) &&
                     (fb_q[3] == crc8rcp_pkg::Mark02);

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    in_frame_d       = in_frame_q;
    kind_d           = kind_q;
    chk_d            = chk_q;
    crc_req.start    = 1'b0;
    crc_req.last_idx = crc8rcp_pkg::CmdLastByte;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && active) begin
          priority if (cmd_match) begin
            in_frame_d       = 1'b0;
            kind_d           = 1'b0;
            chk_d            = fb_q[4];
            crc_req.start    = 1'b1;
            crc_req.last_idx = crc8rcp_pkg::CmdLastByte;
            state_d          = ST_CRC;
          end else if (joy_match) begin
            in_frame_d       = 1'b0;
            kind_d           = 1'b1;
            chk_d            = rx_byte_i;
            crc_req.start    = 1'b1;
            crc_req.last_idx = crc8rcp_pkg::JoyLastByte;
            state_d          = ST_CRC;
          end else if (cnt_new >= crc8rcp_pkg::CntW'(crc8rcp_pkg::MaxFrame)) begin
            // drop an unmatched frame once the buffer is full
            in_frame_d = 1'b0;
          end else begin
            in_frame_d = 1'b1;
            count_d    = cnt_new;
          end
        end
      end
      ST_CRC: begin
        if (crc_rsp.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ok = (crc_val == chk_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      in_frame_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      speed_code_q  <= 8'd7;
      switch_code_q <= 8'd8;
      hold_code_q   <= 8'd9;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      in_frame_q <= in_frame_d;
      if (state_q == ST_CRC && crc_rsp.done) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          crc8rcp_pkg::CfgSpeed:  speed_code_q  <= cfg_data_i;
          crc8rcp_pkg::CfgSwitch: switch_code_q <= cfg_data_i;
          crc8rcp_pkg::CfgHold:   hold_code_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    chk_q  <= chk_d;
    if (in_acc && active) begin
      fb_q[wr_idx[crc8rcp_pkg::IdxW-1:0]] <= rx_byte_i;
    end
    if (state_q == ST_CRC && crc_rsp.done) begin
      frame_kind_o   <= kind_q;
      crc_ok_o       <= ok;
      speed_valid_o  <= !kind_q && ok && (fb_q[2] == speed_code_q);
      speed_value_o  <= (!kind_q && ok && (fb_q[2] == speed_code_q)) ? fb_q[3] : 8'h00;
      switch_valid_o <= !kind_q && ok && (fb_q[2] == switch_code_q);
      switch_value_o <= (!kind_q && ok && (fb_q[2] == switch_code_q)) ? fb_q[3] : 8'h00;
      hold_start_o   <= !kind_q && ok && (fb_q[2] == hold_code_q);
      steer_valid_o  <= kind_q && ok;
      steer_value_o  <= (kind_q && ok) ? fb_q[4] : 8'h00;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_req.start |-> !out_valid_q)
    else $error("check started while a result still waits");
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (count_q != '0) &&
                   (count_q < crc8rcp_pkg::CntW'(crc8rcp_pkg::MaxFrame)))
    else $error("byte count out of range in open frame");
  a_done_in_crc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_rsp.done |-> (state_q == ST_CRC))
    else $error("check finished outside the check state");
  a_out_after_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(crc_rsp.done))
    else $error("result raised without a finished check");
`endif

endmodule

// File: hw/rtl/crc8rcp_crc.sv
`timescale 1ns / 1ps
module crc8rcp_crc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crc8rcp_pkg::crc_req_t req_i,
  input  logic [7:0]            data_i,
  output crc8rcp_pkg::crc_rsp_t rsp_o,
  output logic [7:0]            crc_o
);

  logic [7:0] crc_q, crc_d;
  logic [2:0] bit_q, bit_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] last_q, last_d;
  logic       run_q, run_d;
  logic       done_q, done_d;
  logic       fb;

  // One bit per cycle, MSB first
  assign fb = crc_q[7] ^ data_i[3'd7 - bit_q];

  always_comb begin
    crc_d  = crc_q;
    bit_d  = bit_q;
    idx_d  = idx_q;
    last_d = last_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      crc_d  = 8'h00;
      bit_d  = 3'd0;
      idx_d  = 3'd0;
      last_d = req_i.last_idx;
      run_d  = 1'b1;
    end else if (run_q) begin
      crc_d = {crc_q[6:0], 1'b0} ^ (fb ? crc8rcp_pkg::CrcPoly : 8'h00);
      bit_d = bit_q + 3'd1;
      if (bit_q == 3'd7) begin
        if (idx_q == last_q) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= 3'd0;
      idx_q  <= 3'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      bit_q  <= bit_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q  <= crc_d;
    last_q <= last_d;
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.idx  = idx_q;
  assign crc_o      = crc_q;

endmodule
